[hw/rtl/gftl_pkg.sv]
// ----------------------------------------------------------------------------
// gftl_pkg
// Shared types and constants for the GOOSE frame TLV locator.
// ----------------------------------------------------------------------------
package gftl_pkg;

    localparam int POS_W             = 16;
    localparam int OFS_W             = 25;
    localparam int ACC_W             = 24;
    localparam int MAX_FRAME_BYTES   = 65535;
    localparam int MAX_LENGTH_OCTETS = 3;

    localparam logic [15:0] ETH_GOOSE = 16'h88b8;
    localparam logic [15:0] ETH_VLAN  = 16'h8100;
    localparam logic [15:0] ETH_PTP   = 16'h88f7;
    localparam logic [7:0]  TAG_SEQ   = 8'h61;
    localparam logic [7:0]  TAG_ALLD  = 8'hAB;

    localparam logic [4:0]  APDU_OFS_PLAIN  = 5'd22;
    localparam logic [4:0]  APDU_OFS_TAGGED = 5'd26;

    localparam int OUT_BITS   = 100;
    localparam int TDATA_OUT_W = 104;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SEQ_LEN0,
        PH_SEQ_LENX,
        PH_WAIT,
        PH_CHILD_LEN0,
        PH_CHILD_LENX,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_PTP,
        CLS_GOOSE
    } class_t;

    typedef enum logic [1:0] {
        ST_FOUND,
        ST_NOT_FOUND,
        ST_BAD_LEN,
        ST_EXCEEDS
    } status_t;

    // one buffered input word
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } in_word_t;

    // result, last field in the lowest bits
    typedef struct packed {
        logic [OFS_W-1:0] alldata_value_end;
        logic [15:0]      alldata_value_start;
        logic             alldata_found;
        logic [15:0]      seq_value_end;
        logic [15:0]      seq_value_start;
        status_t          seq_status;
        logic [4:0]       apdu_offset;
        logic [15:0]      frame_length;
        logic             vlan_tagged;
        class_t           frame_class;
    } result_t;

endpackage

[hw/rtl/goose_frame_tlv_locator.sv]
// ----------------------------------------------------------------------------
// goose_frame_tlv_locator
// Classes Ethernet frames (PTP / GOOSE / other) and locates the GOOSE APDU
// sequence and its allData value region, one result word per frame.
// ----------------------------------------------------------------------------
//  channel   dir  word                          handshake
//  s_axis    in   one frame octet, tlast=final  tvalid & tready
//  m_axis    out  one result per frame          tvalid & tready
//
//  One octet per clock sustained; each octet passes input register, parser
//  logic and (on tlast) the result register, which drives the result on m_axis.
//  Stall on m_axis holds the result; further octets of the next frame keep
//  flowing until that frame's tlast needs the result register.
//  rst_n (async, low) clears both valid flags and all parser state.
// ----------------------------------------------------------------------------
module goose_frame_tlv_locator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] byte_value
    input  logic                             s_axis_tlast,  // last_byte
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] frame_class, [2] vlan_tagged, [18:3] frame_length,
    // [23:19] apdu_offset, [25:24] seq_status, [41:26] seq_value_start,
    // [57:42] seq_value_end, [58] alldata_found, [74:59] alldata_value_start,
    // [99:75] alldata_value_end, [103:100] zero
    output logic [gftl_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import gftl_pkg::*;

    in_word_t word;
    result_t  result;
    logic     pop;
    logic     can_load;
    logic     load;

    // a final word waits until the result register is free
    assign pop  = word.valid && (!word.last || can_load);
    assign load = pop && word.last;

    gftl_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .pop           (pop),
        .word          (word)
    );

    gftl_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (word),
        .pop    (pop),
        .result (result)
    );

    gftl_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .result        (result),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[hw/rtl/gftl_in_reg.sv]
// ----------------------------------------------------------------------------
// gftl_in_reg
// Input register: holds one word until the parser consumes it.
// ----------------------------------------------------------------------------
module gftl_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              pop,
    output gftl_pkg::in_word_t word
);
    import gftl_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       accept;

    assign s_axis_tready = !valid_reg || pop;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign valid_next    = accept ? 1'b1 : (pop ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;
    assign word.last  = last_reg;

endmodule

[hw/rtl/gftl_parser.sv]
// ----------------------------------------------------------------------------
// gftl_parser
// Per-octet header, BER length and child TLV walk; builds the frame result.
// ----------------------------------------------------------------------------
module gftl_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  gftl_pkg::in_word_t word,
    input  logic              pop,
    output gftl_pkg::result_t result
);
    import gftl_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    logic [15:0]      outer_reg, outer_next, outer_upd;
    logic [15:0]      inner_reg, inner_next, inner_upd;
    phase_t           phase_reg, phase_next, phase_upd;
    logic [OFS_W-1:0] seq_end_reg, seq_end_next, seq_end_upd;
    logic [OFS_W-1:0] child_start_reg, child_start_next, child_start_upd;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_upd;
    logic [1:0]       left_reg, left_next, left_upd;
    logic             child_ad_reg, child_ad_next, child_ad_upd;
    logic             walk_done_reg, walk_done_next, walk_done_upd;
    status_t          pend_reg, pend_next, pend_upd;
    logic [15:0]      seq_start_reg, seq_start_next, seq_start_upd;
    logic [15:0]      ad_start_reg, ad_start_next, ad_start_upd;
    logic [OFS_W-1:0] ad_end_reg, ad_end_next, ad_end_upd;

    logic [POS_W-1:0] pos_p1;
    logic [7:0]       b;
    logic [6:0]       n;
    logic [ACC_W-1:0] acc_val;
    logic [OFS_W-1:0] sum;
    logic [1:0]       left_dec;
    logic             active;
    logic             bad_n;

    assign b        = word.data;
    assign n        = b[6:0];
    assign active   = pos_reg < POS_W'(MAX_FRAME_BYTES);
    assign pos_p1   = pos_reg + 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign bad_n    = (n == 7'd0) || (n > 7'(MAX_LENGTH_OCTETS));
    assign acc_val  = (phase_reg == PH_SEQ_LENX || phase_reg == PH_CHILD_LENX) ?
                      {acc_reg[ACC_W-9:0], b} : {{(ACC_W-8){1'b0}}, b};
    // shared: sequence end on begin-walk, next child start or allData end on child length done
    assign sum      = OFS_W'(pos_p1) + OFS_W'(acc_val);

    always_comb
    begin
        pos_upd         = pos_reg;
        outer_upd       = outer_reg;
        inner_upd       = inner_reg;
        phase_upd       = phase_reg;
        seq_end_upd     = seq_end_reg;
        child_start_upd = child_start_reg;
        acc_upd         = acc_reg;
        left_upd        = left_reg;
        child_ad_upd    = child_ad_reg;
        walk_done_upd   = walk_done_reg;
        pend_upd        = pend_reg;
        seq_start_upd   = seq_start_reg;
        ad_start_upd    = ad_start_reg;
        ad_end_upd      = ad_end_reg;

        if (active)
        begin
            pos_upd = pos_p1;
            if (pos_reg == POS_W'(12)) outer_upd[15:8] = b;
            if (pos_reg == POS_W'(13)) outer_upd[7:0]  = b;
            if (pos_reg == POS_W'(16)) inner_upd[15:8] = b;
            if (pos_reg == POS_W'(17)) inner_upd[7:0]  = b;

            unique case (phase_reg)
                PH_HDR:
                begin
                    if (pos_reg == ((outer_reg == ETH_VLAN) ? POS_W'(APDU_OFS_TAGGED)
                                                             : POS_W'(APDU_OFS_PLAIN)))
                    begin
                        if (b == TAG_SEQ)
                        begin
                            phase_upd = PH_SEQ_LEN0;
                        end
                        else
                        begin
                            pend_upd  = ST_NOT_FOUND;
                            phase_upd = PH_FAIL;
                        end
                    end
                end
                PH_SEQ_LEN0, PH_SEQ_LENX:
                begin
                    if (phase_reg == PH_SEQ_LEN0 && b[7])
                    begin
                        if (bad_n)
                        begin
                            pend_upd  = ST_BAD_LEN;
                            phase_upd = PH_FAIL;
                        end
                        else
                        begin
                            left_upd  = n[1:0];
                            acc_upd   = '0;
                            phase_upd = PH_SEQ_LENX;
                        end
                    end
                    else
                    begin
                        acc_upd = acc_val;
                        if (phase_reg == PH_SEQ_LENX)
                        begin
                            left_upd = left_dec;
                        end
                        if (phase_reg == PH_SEQ_LEN0 || left_dec == 2'd0)
                        begin
                            // begin walk over the sequence's children
                            seq_start_upd   = pos_p1;
                            seq_end_upd     = sum;
                            child_start_upd = OFS_W'(pos_p1);
                            phase_upd       = PH_WAIT;
                            if (acc_val < ACC_W'(2)) walk_done_upd = 1'b1;
                        end
                    end
                end
                PH_WAIT:
                begin
                    if (!walk_done_reg && OFS_W'(pos_reg) == child_start_reg)
                    begin
                        child_ad_upd = (b == TAG_ALLD);
                        phase_upd    = PH_CHILD_LEN0;
                    end
                end
                PH_CHILD_LEN0, PH_CHILD_LENX:
                begin
                    if (phase_reg == PH_CHILD_LEN0 && b[7])
                    begin
                        if (bad_n || ((OFS_W+1)'(pos_p1) + (OFS_W+1)'(n) >
                                      (OFS_W+1)'(seq_end_reg)))
                        begin
                            walk_done_upd = 1'b1;
                            phase_upd     = PH_WAIT;
                        end
                        else
                        begin
                            left_upd  = n[1:0];
                            acc_upd   = '0;
                            phase_upd = PH_CHILD_LENX;
                        end
                    end
                    else
                    begin
                        acc_upd = acc_val;
                        if (phase_reg == PH_CHILD_LENX)
                        begin
                            left_upd = left_dec;
                        end
                        if (phase_reg == PH_CHILD_LEN0 || left_dec == 2'd0)
                        begin
                            phase_upd = PH_WAIT;
                            if (child_ad_reg)
                            begin
                                ad_start_upd  = pos_p1;
                                ad_end_upd    = sum;
                                walk_done_upd = 1'b1;
                            end
                            else if (sum > seq_end_reg)
                            begin
                                walk_done_upd = 1'b1;
                            end
                            else
                            begin
                                child_start_upd = sum;
                                if ((OFS_W+1)'(sum) + (OFS_W+1)'(2) > (OFS_W+1)'(seq_end_reg))
                                begin
                                    walk_done_upd = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_FAIL:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame result from the state after this octet
    always_comb
    begin
        result = '0;
        result.frame_length = pos_upd;
        result.seq_status   = ST_NOT_FOUND;
        result.frame_class  = CLS_OTHER;
        if ((pos_upd >= POS_W'(14) && outer_upd == ETH_PTP) ||
            (pos_upd >= POS_W'(18) && outer_upd == ETH_VLAN && inner_upd == ETH_PTP))
        begin
            result.frame_class = CLS_PTP;
        end
        else if (pos_upd >= POS_W'(APDU_OFS_PLAIN))
        begin
            if (outer_upd == ETH_VLAN)
            begin
                if (pos_upd >= POS_W'(APDU_OFS_TAGGED) && inner_upd == ETH_GOOSE)
                begin
                    result.frame_class = CLS_GOOSE;
                    result.vlan_tagged = 1'b1;
                    result.apdu_offset = APDU_OFS_TAGGED;
                end
            end
            else if (outer_upd == ETH_GOOSE)
            begin
                result.frame_class = CLS_GOOSE;
                result.apdu_offset = APDU_OFS_PLAIN;
            end
        end

        if (result.frame_class == CLS_GOOSE)
        begin
            unique case (phase_upd)
                PH_HDR, PH_SEQ_LEN0: result.seq_status = ST_NOT_FOUND;
                PH_SEQ_LENX:         result.seq_status = ST_BAD_LEN;
                PH_FAIL:             result.seq_status = pend_upd;
                default:
                    result.seq_status = (seq_end_upd > OFS_W'(pos_upd)) ? ST_EXCEEDS
                                                                         : ST_FOUND;
            endcase
            if (result.seq_status == ST_FOUND)
            begin
                result.seq_value_start     = seq_start_upd;
                result.seq_value_end       = seq_end_upd[15:0];
                result.alldata_value_start = ad_start_upd;
                result.alldata_value_end   = ad_end_upd;
                result.alldata_found       = (ad_start_upd != 16'd0);
            end
        end
    end

    // state returns to reset after the last word of a frame
    always_comb
    begin
        pos_next         = pos_reg;
        outer_next       = outer_reg;
        inner_next       = inner_reg;
        phase_next       = phase_reg;
        seq_end_next     = seq_end_reg;
        child_start_next = child_start_reg;
        acc_next         = acc_reg;
        left_next        = left_reg;
        child_ad_next    = child_ad_reg;
        walk_done_next   = walk_done_reg;
        pend_next        = pend_reg;
        seq_start_next   = seq_start_reg;
        ad_start_next    = ad_start_reg;
        ad_end_next      = ad_end_reg;
        if (pop && word.last)
        begin
            pos_next         = '0;
            outer_next       = '0;
            inner_next       = '0;
            phase_next       = PH_HDR;
            seq_end_next     = '0;
            child_start_next = '0;
            acc_next         = '0;
            left_next        = '0;
            child_ad_next    = 1'b0;
            walk_done_next   = 1'b0;
            pend_next        = ST_FOUND;
            seq_start_next   = '0;
            ad_start_next    = '0;
            ad_end_next      = '0;
        end
        else if (pop)
        begin
            pos_next         = pos_upd;
            outer_next       = outer_upd;
            inner_next       = inner_upd;
            phase_next       = phase_upd;
            seq_end_next     = seq_end_upd;
            child_start_next = child_start_upd;
            acc_next         = acc_upd;
            left_next        = left_upd;
            child_ad_next    = child_ad_upd;
            walk_done_next   = walk_done_upd;
            pend_next        = pend_upd;
            seq_start_next   = seq_start_upd;
            ad_start_next    = ad_start_upd;
            ad_end_next      = ad_end_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            outer_reg       <= '0;
            inner_reg       <= '0;
            phase_reg       <= PH_HDR;
            seq_end_reg     <= '0;
            child_start_reg <= '0;
            acc_reg         <= '0;
            left_reg        <= '0;
            child_ad_reg    <= 1'b0;
            walk_done_reg   <= 1'b0;
            pend_reg        <= ST_FOUND;
            seq_start_reg   <= '0;
            ad_start_reg    <= '0;
            ad_end_reg      <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            outer_reg       <= outer_next;
            inner_reg       <= inner_next;
            phase_reg       <= phase_next;
            seq_end_reg     <= seq_end_next;
            child_start_reg <= child_start_next;
            acc_reg         <= acc_next;
            left_reg        <= left_next;
            child_ad_reg    <= child_ad_next;
            walk_done_reg   <= walk_done_next;
            pend_reg        <= pend_next;
            seq_start_reg   <= seq_start_next;
            ad_start_reg    <= ad_start_next;
            ad_end_reg      <= ad_end_next;
        end
    end

endmodule

[hw/rtl/gftl_out_reg.sv]
// ----------------------------------------------------------------------------
// gftl_out_reg
// Result register on the master side.
// ----------------------------------------------------------------------------
module gftl_out_reg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  gftl_pkg::result_t                    result,
    output logic                                 can_load,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [gftl_pkg::TDATA_OUT_W-1:0]     m_axis_tdata
);
    import gftl_pkg::*;

    logic                   valid_reg, valid_next;
    logic [TDATA_OUT_W-1:0] data_reg;

    assign can_load   = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {(TDATA_OUT_W-OUT_BITS)'(0), result};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

[hw/rtl/gftl_checker.sv]
// ----------------------------------------------------------------------------
// gftl_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gftl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gftl_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import gftl_pkg::*;

    logic [1:0] cls;
    logic       vlan;
    logic [4:0] ofs;
    logic [1:0] st;

    assign cls  = m_axis_tdata[1:0];
    assign vlan = m_axis_tdata[2];
    assign ofs  = m_axis_tdata[23:19];
    assign st   = m_axis_tdata[25:24];

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_non_goose: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cls != CLS_GOOSE |->
            ofs == 5'd0 && !vlan && st == ST_NOT_FOUND)
        else $error("non-GOOSE frame carries GOOSE fields");

    a_apdu_ofs: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && cls == CLS_GOOSE |->
            ofs == (vlan ? APDU_OFS_TAGGED : APDU_OFS_PLAIN))
        else $error("APDU offset does not match tagging");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st != ST_FOUND |->
            m_axis_tdata[41:26] == 16'd0 && !m_axis_tdata[58])
        else $error("offsets reported for a sequence not found");

endmodule

bind goose_frame_tlv_locator gftl_checker u_gftl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
